@@ rtl/surplus_power_diversion_controller_assert.svh @@
// Assertion macros shared by the diversion controller modules
`ifndef SURPLUS_POWER_DIVERSION_CONTROLLER_ASSERT_SVH
`define SURPLUS_POWER_DIVERSION_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
`define SPDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SPDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SPDC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SPDC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/spdc_pkg.sv @@
// Package: types, codes and constants of the diversion controller
`timescale 1ns / 1ps
package spdc_pkg;

	localparam int LOAD_W   = 16;
	localparam int TARGET_W = 15;
	localparam int BASE_W   = 7;
	localparam int POWER_W  = 17;
	localparam int PCT_W    = 7;
	localparam int ACC_W    = 15;
	localparam int ERR_W    = 18;
	localparam int MAG_W    = 17;
	localparam int QUO_W    = 32;
	localparam int REM_W    = 17;
	localparam int STEP_W   = 33;
	localparam int SUM_W    = 35;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIV_STEPS  = QUO_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	localparam logic [ACC_W-1:0]    FULL_SCALE  = 15'd25344;
	localparam logic [QUO_W-1:0]    STEP_GAIN   = 32'd25600;
	localparam logic [PCT_W-1:0]    MAX_PERCENT = 7'd99;
	localparam logic [LOAD_W-1:0]   LOAD_RST    = 16'd1000;
	localparam logic [TARGET_W-1:0] TARGET_RST  = -15'sd40;
	localparam logic [BASE_W-1:0]   BASE_RST    = 7'd20;

	localparam logic [CFG_IDX_W-1:0] REG_LOAD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd2;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_ON   = 2'd1,
		MODE_ECO  = 2'd2,
		MODE_BASE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULT,
		ST_DIV,
		ST_STEP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load_in;
		logic mult;
		logic div_step;
		logic step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic kind;
	} status_t;

endpackage

@@ rtl/spdc_ctrl.sv @@
// Controller state machine: sequences accept, multiply, divide, step and commit
`timescale 1ns / 1ps
`include "surplus_power_diversion_controller_assert.svh"
module spdc_ctrl
	import spdc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic               out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step)
				cnt_q <= cnt_q + CNT_W'(1);
			else
				cnt_q <= '0;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_MULT;
				end
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
				state_d  = status.kind ? ST_FIN : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = ST_STEP;
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d  = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`SPDC_ASSERT_IMP(a_commit_free, clk, arst_n, cmd.commit, !out_valid_q || out_ready)
	`SPDC_ASSERT_NXT(a_accept_mult, clk, arst_n, in_valid && in_ready, state_q == ST_MULT)
	`SPDC_ASSERT_IMP(a_div_len, clk, arst_n, state_q == ST_STEP, $past(cnt_q) == CNT_W'(DIV_STEPS - 1))

endmodule

@@ rtl/spdc_dp.sv @@
// Datapath: configuration, error multiply, serial divider, accumulator and mode
`timescale 1ns / 1ps
`include "surplus_power_diversion_controller_assert.svh"
module spdc_dp
	import spdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_kind,
	input  logic [POWER_W-1:0]    in_power,
	input  cmd_t                  cmd,
	output status_t               status,
	output logic [PCT_W-1:0]      drive_percent,
	output logic [PCT_W-1:0]      controller_percent,
	output logic [1:0]            mode_now
);

	logic [LOAD_W-1:0]          load_q;
	logic signed [TARGET_W-1:0] target_q;
	logic [BASE_W-1:0]          base_q;

	logic                       kind_q;
	logic signed [ERR_W-1:0]    err_q;
	logic [REM_W-1:0]           rem_q;
	logic [QUO_W-1:0]           quo_q;
	logic signed [STEP_W-1:0]   step_q;
	logic [ACC_W-1:0]           accum_q;
	mode_t                      mode_q;
	logic [PCT_W-1:0]           last_drive_q;
	logic [PCT_W-1:0]           drive_out_q, ctrl_out_q;
	logic [1:0]                 mode_out_q;

	logic [ERR_W-1:0]           err_abs;
	logic [REM_W:0]             shifted, trial;
	logic                       err_pos, importing;
	logic signed [ERR_W-1:0]    target_mag;
	logic [QUO_W-1:0]           quo_eff;
	logic signed [STEP_W-1:0]   step_raw;
	logic signed [SUM_W-1:0]    sum;
	logic [ACC_W-1:0]           accum_new;
	logic [PCT_W-1:0]           ctrl_new, base_eff, drive_new;
	mode_t                      mode_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q   <= LOAD_RST;
			target_q <= TARGET_RST;
			base_q   <= BASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOAD:   load_q   <= cfg_data[LOAD_W-1:0];
				REG_TARGET: target_q <= cfg_data[TARGET_W-1:0];
				REG_BASE:   base_q   <= cfg_data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		err_abs    = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
		shifted    = {rem_q, quo_q[QUO_W-1]};
		trial      = shifted - {{(REM_W + 1 - LOAD_W){1'b0}}, load_q};
		err_pos    = !err_q[ERR_W-1] && (err_q != '0);
		target_mag = target_q[TARGET_W-1] ? -ERR_W'(target_q) : ERR_W'(target_q);
		importing  = err_pos && (err_q > target_mag);
		quo_eff    = (load_q == '0) ? '0 : quo_q;
		step_raw   = err_pos ? -$signed({1'b0, quo_eff}) : $signed({1'b0, quo_eff});
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= in_kind;
			err_q  <= $signed({in_power[POWER_W-1], in_power})
				- ERR_W'(target_q);
		end
		if (cmd.mult) begin
			rem_q <= '0;
			quo_q <= {{(QUO_W - MAG_W){1'b0}}, err_abs[MAG_W-1:0]} * STEP_GAIN;
		end else if (cmd.div_step) begin
			if (!trial[REM_W]) begin
				rem_q <= trial[REM_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[REM_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
		if (cmd.step)
			step_q <= importing ? (step_raw >>> 1) : (step_raw >>> 2);
	end

	always_comb begin
		sum = $signed({{(SUM_W - ACC_W){1'b0}}, accum_q}) + SUM_W'(step_q);
		if (sum < 0)
			accum_new = '0;
		else if (sum >= $signed({{(SUM_W - ACC_W){1'b0}}, FULL_SCALE}))
			accum_new = FULL_SCALE;
		else
			accum_new = sum[ACC_W-1:0];
		ctrl_new  = accum_new[ACC_W-1:ACC_W-PCT_W];
		base_eff  = (base_q > MAX_PERCENT) ? MAX_PERCENT : base_q;
		case (mode_q)
			MODE_OFF:  drive_new = '0;
			MODE_ON:   drive_new = MAX_PERCENT;
			MODE_ECO:  drive_new = ctrl_new;
			MODE_BASE: drive_new = (ctrl_new < base_eff) ? base_eff : ctrl_new;
			default:   drive_new = '0;
		endcase
		mode_next = mode_t'(mode_q + 2'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q      <= '0;
			mode_q       <= MODE_ECO;
			last_drive_q <= '0;
		end else if (cmd.commit) begin
			if (kind_q) begin
				mode_q <= mode_next;
			end else begin
				accum_q      <= accum_new;
				last_drive_q <= drive_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (kind_q) begin
				drive_out_q <= last_drive_q;
				ctrl_out_q  <= accum_q[ACC_W-1:ACC_W-PCT_W];
				mode_out_q  <= mode_next;
			end else begin
				drive_out_q <= drive_new;
				ctrl_out_q  <= ctrl_new;
				mode_out_q  <= mode_q;
			end
		end
	end

	assign status.kind        = kind_q;
	assign drive_percent      = drive_out_q;
	assign controller_percent = ctrl_out_q;
	assign mode_now           = mode_out_q;

	`SPDC_ASSERT_IMP(a_accum_range, clk, arst_n, 1'b1, accum_q <= FULL_SCALE)
	`SPDC_ASSERT_NXT(a_key_mode, clk, arst_n, cmd.commit && kind_q, mode_q == mode_t'($past(mode_q) + 2'd1))
	`SPDC_ASSERT_IMP(a_drive_range, clk, arst_n, 1'b1, last_drive_q <= MAX_PERCENT)

endmodule

@@ rtl/surplus_power_diversion_controller.sv @@
// Top level of the surplus power diversion controller
//
// Input stream s_*: one transfer per item. s_tuser is the item kind (0 power
// report, 1 key press), s_tdata[16:0] the signed net power in watts.
// Output stream m_*: one transfer per input item carrying drive percent,
// controller percent and the mode after the item.
// Configuration channel cfg_*: always ready; index 0 load watts, 1 target
// watts, 2 base percent; other indexes are ignored. Write only while idle.
// A power report goes through these steps: the error is formed at the
// transfer edge, then the multiply, the bit-serial restoring divider, the
// step scaling and the clamp and commit. A key press skips the divider
// and the step scaling. s_tready returns in the cycle after the result is
// registered.
// One item is in work at a time; s_tready is high only while idle.
// A result waits in the output register while m_tready is low; the next item
// may be accepted meanwhile and stalls at commit until the register frees.
// Reset clears the accumulator and last drive, sets eco mode and restores the
// configuration defaults (1000 W, -40 W, 20 %).
`timescale 1ns / 1ps
module surplus_power_diversion_controller
	import spdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // [16:0] power_watts, rest zero
	input  logic                  s_tuser,   // [0] kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // [6:0] drive_percent,
	                                         // [13:7] controller_percent,
	                                         // [15:14] mode_now
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t             cmd;
	status_t          status;
	logic [PCT_W-1:0] drive_percent, controller_percent;
	logic [1:0]       mode_now;

	assign cfg_ready = 1'b1;

	spdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	spdc_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_valid && cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_kind            (s_tuser),
		.in_power           (s_tdata[POWER_W-1:0]),
		.cmd                (cmd),
		.status             (status),
		.drive_percent      (drive_percent),
		.controller_percent (controller_percent),
		.mode_now           (mode_now)
	);

	assign m_tdata = {mode_now, controller_percent, drive_percent};

endmodule

@@ sim/tb_surplus_power_diversion_controller.sv @@
// Self-checking testbench for the surplus power diversion controller stream interface
`timescale 1ns / 1ps
module tb_surplus_power_diversion_controller;
	import spdc_pkg::*;

	localparam longint PCT_GAIN    = 25600;
	localparam longint PCT_CEIL    = 25344;
	localparam int     PCT_TOP     = 99;
	localparam int     POWER_MAX   = 65535;
	localparam int     POWER_MIN   = -65536;
	localparam int     TARGET_MAX  = 16383;
	localparam int     TARGET_MIN  = -16384;
	localparam int     HOLD_CYCLES = 300;
	localparam int     DRAIN_WAIT  = 40;
	localparam int     CYCLE_LIMIT = 1500000;
	localparam int     PHASES      = 16;
	localparam int     PHASE_ITEMS = 103;

	typedef struct packed {
		mode_t      mode;
		logic [6:0] ctrl;
		logic [6:0] drive;
	} drive_result_t;

	class drive_ledger;
		int            load_w;
		int            target_w;
		int            base_p;
		int            accum;
		int            last_drive;
		int            errors;
		mode_t         mode;
		drive_result_t due[$];

		function new();
			load_w     = 1000;
			target_w   = -40;
			base_p     = 20;
			accum      = 0;
			last_drive = 0;
			errors     = 0;
			mode       = MODE_ECO;
		endfunction

		function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_LOAD: load_w = int'(data);
				REG_TARGET: target_w = int'($signed(data[14:0]));
				REG_BASE: base_p = int'(data[6:0]);
				default: ;
			endcase
		endfunction

		function void predict_item(bit kind, int power);
			longint        err;
			longint        mag;
			longint        step;
			longint        sum;
			int            ctrl;
			int            floor_pct;
			drive_result_t r;
			if (!kind) begin
				err  = longint'(power) - longint'(target_w);
				mag  = (target_w < 0) ? -target_w : target_w;
				step = 0;
				if (load_w != 0)
					step = -(PCT_GAIN * err) / longint'(load_w);
				if (err > 0 && err > mag)
					step = step >>> 1;
				else
					step = step >>> 2;
				sum = accum + step;
				if (sum < 0)
					sum = 0;
				if (sum >= PCT_CEIL)
					sum = PCT_CEIL;
				accum     = int'(sum);
				ctrl      = accum >> 8;
				floor_pct = (base_p > PCT_TOP) ? PCT_TOP : base_p;
				case (mode)
					MODE_OFF: last_drive = 0;
					MODE_ON: last_drive = PCT_TOP;
					MODE_ECO: last_drive = ctrl;
					default: last_drive = (ctrl < floor_pct) ? floor_pct : ctrl;
				endcase
			end else begin
				mode = mode.next();
			end
			r.drive = 7'(last_drive);
			r.ctrl  = 7'(accum >> 8);
			r.mode  = mode;
			due.push_back(r);
		endfunction

		function void check_result(logic [15:0] data);
			drive_result_t e;
			if (due.size() == 0) begin
				$display("%0t: unexpected result, got %h", $time, data);
				errors++;
				return;
			end
			e = due.pop_front();
			if (data[6:0] !== e.drive) begin
				$display("%0t: drive_percent expected %0d, got %0d", $time, e.drive, data[6:0]);
				errors++;
			end
			if (data[13:7] !== e.ctrl) begin
				$display("%0t: controller_percent expected %0d, got %0d", $time, e.ctrl,
					data[13:7]);
				errors++;
			end
			if (data[15:14] !== e.mode) begin
				$display("%0t: mode_now expected %0d, got %0d", $time, e.mode, data[15:14]);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [23:0]           s_tdata;   // [16:0] power_watts, rest zero
	logic                  s_tuser;   // [0] kind
	logic                  m_tvalid;
	logic                  m_tready;
	logic [15:0]           m_tdata;   // [6:0] drive_percent, [13:7] controller_percent,
	                                  // [15:14] mode_now
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	drive_ledger ledger;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          rx_wait;
	int          hold_left;
	bit          hold_req;
	int          cycles;

	surplus_power_diversion_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic int rand_power(int target);
		logic signed [16:0] raw;
		int                 p;
		raw = 17'($urandom);
		case ($urandom_range(0, 9))
			0: p = int'(raw);
			1: p = $urandom_range(0, 1) ? POWER_MAX : POWER_MIN;
			default: begin
				p = target + int'($urandom_range(0, 4000)) - 2000;
				if (p > POWER_MAX)
					p = POWER_MAX;
				if (p < POWER_MIN)
					p = POWER_MIN;
			end
		endcase
		return p;
	endfunction

	// retire results and pace the receiver
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("surplus_power_diversion_controller regression: fail");
			$finish;
		end
		if (m_tvalid && m_tready)
			ledger.check_result(m_tdata);
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else begin
			rx_wait = pick_gap(rx_idle_pct);
			m_tready <= (rx_wait == 0);
			if (rx_wait > 0)
				rx_wait--;
		end
	end

	task automatic send_item(bit kind, int power);
		int gap;
		gap = pick_gap(tx_idle_pct);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {7'd0, 17'(power)};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		ledger.predict_item(kind, power);
	endtask

	task automatic report(int power);
		send_item(1'b0, power);
	endtask

	task automatic key_press(int power);
		send_item(1'b1, power);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (ledger.due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		ledger.apply_write(idx, data);
	endtask

	task automatic configure(logic [15:0] load, logic [15:0] target, logic [15:0] base);
		write_reg(REG_LOAD, load);
		write_reg(REG_TARGET, target);
		write_reg(REG_BASE, base);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_config();
		int          t;
		int          b;
		logic [15:0] load;
		case ($urandom_range(0, 7))
			0: load = 16'd0;
			1: load = 16'd1;
			2: load = 16'hFFFF;
			3: load = 16'($urandom_range(1, 65535));
			default: load = 16'($urandom_range(100, 5000));
		endcase
		case ($urandom_range(0, 5))
			0: t = TARGET_MIN;
			1: t = TARGET_MAX;
			2: t = int'($urandom_range(0, 32767)) + TARGET_MIN;
			default: t = int'($urandom_range(0, 2000)) - 1000;
		endcase
		case ($urandom_range(0, 5))
			0: b = 0;
			1: b = PCT_TOP;
			2: b = 127;
			default: b = $urandom_range(0, PCT_TOP);
		endcase
		configure(load, {1'($urandom), 15'(t)}, {9'($urandom), 7'(b)});
	endtask

	initial begin
		int  ph;
		int  n;
		bit  kind;
		clk         = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		m_tready    = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_wait     = 0;
		hold_left   = 0;
		hold_req    = 0;
		cycles      = 0;
		ledger      = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: clamps, half and quarter steps, every mode
		report(POWER_MIN);
		report(POWER_MAX);
		report(-3000);
		report(-20);
		report(100);
		report(-40);
		key_press(POWER_MAX);
		report(-300);
		key_press(-1);
		report(-5000);
		key_press(0);
		report(0);
		key_press(POWER_MIN);
		settle();

		// zero load holds the accumulator; base above range
		configure(16'd0, 16'd0, 16'hFF7F);
		key_press(1);
		report(1234);
		report(POWER_MIN);
		settle();

		configure(16'd1, 16'h3FFF, 16'h0000);
		report(POWER_MIN);
		report(POWER_MAX);
		report(16000);
		settle();

		configure(16'hFFFF, 16'hC000, 16'd99);
		report(TARGET_MIN);
		report(-16000);
		report(10000);
		key_press(0);
		settle();

		for (ph = 0; ph < PHASES; ph++) begin
			random_config();
			if (ph == 0) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
				rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
			end
			// stall the receiver while the sender keeps offering
			if (ph == 3 || ph == 11) begin
				tx_idle_pct = 0;
				hold_req    = 1;
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				kind = ($urandom_range(0, 99) < 15);
				if (kind)
					key_press(int'($signed(17'($urandom))));
				else
					report(rand_power(ledger.target_w));
			end
			settle();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (ledger.errors == 0 && ledger.due.size() == 0)
			$display("surplus_power_diversion_controller regression: pass");
		else
			$display("surplus_power_diversion_controller regression: fail");
		$finish;
	end

endmodule
